>>> sv/fcc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the framed packet checker.
package fcc_pkg;

	localparam int MAX_BURST = 512;
	localparam int COUNT_W = 10;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [7:0] HDR_BYTE = 8'hAA;
	localparam logic [7:0] TAIL_BYTE = 8'hBB;
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam int LEN_POS = 17;
	localparam int ID_POS = 2;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_IDLE = 1'b1;

	typedef enum logic [2:0] {
		STAT_OK = 3'd0,
		STAT_OVERLONG = 3'd1,
		STAT_BAD_HEADER = 3'd2,
		STAT_SHORT = 3'd3,
		STAT_BAD_TAIL = 3'd4,
		STAT_CRC_MISMATCH = 3'd5
	} frame_status_t;

	typedef struct packed {
		frame_status_t status;
		logic [7:0] id;
		logic [8:0] length;
	} result_t;

	// Reflected CRC-8, one byte, eight shift steps.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> sv/fcc_tracker.sv
// Burst state: byte count, running CRC, captured fields and check flags, plus the status decode.
module fcc_tracker (
	input logic clk,
	input logic arst_n,
	input logic evt_valid,
	input logic evt_command,
	input logic [7:0] evt_byte,
	output fcc_pkg::result_t result
);
	import fcc_pkg::*;

	logic [COUNT_W-1:0] byte_count_q, byte_count_d;
	logic [7:0] running_crc_q, running_crc_d;
	logic [7:0] payload_length_q, payload_length_d;
	logic [7:0] captured_id_q, captured_id_d;
	logic header_good_q, header_good_d;
	logic tail_good_q, tail_good_d;
	logic crc_good_q, crc_good_d;

	logic [COUNT_W-1:0] last_pos;
	logic [COUNT_W-1:0] need_count;
	logic [7:0] crc_step;

	assign last_pos = COUNT_W'(LEN_POS + 1) + {2'b00, payload_length_q};
	assign need_count = COUNT_W'(LEN_POS + 3) + {2'b00, payload_length_q};
	assign crc_step = crc8_update(running_crc_q, evt_byte);

	always_comb begin
		byte_count_d = byte_count_q;
		running_crc_d = running_crc_q;
		payload_length_d = payload_length_q;
		captured_id_d = captured_id_q;
		header_good_d = header_good_q;
		tail_good_d = tail_good_q;
		crc_good_d = crc_good_q;
		if (evt_valid && evt_command == CMD_IDLE) begin
			// The burst has ended; everything returns to its reset value.
			byte_count_d = '0;
			running_crc_d = '0;
			payload_length_d = '0;
			captured_id_d = '0;
			header_good_d = 1'b1;
			tail_good_d = 1'b1;
			crc_good_d = 1'b0;
		end else if (evt_valid) begin
			if (byte_count_q < COUNT_W'(2) && evt_byte != HDR_BYTE) begin
				header_good_d = 1'b0;
			end
			if (byte_count_q == COUNT_W'(ID_POS)) begin
				captured_id_d = evt_byte;
			end
			if (byte_count_q < COUNT_W'(LEN_POS) || byte_count_q <= last_pos) begin
				running_crc_d = crc_step;
			end
			if (byte_count_q == COUNT_W'(LEN_POS - 1)) begin
				payload_length_d = evt_byte;
			end
			if (byte_count_q >= COUNT_W'(LEN_POS)
					&& (byte_count_q == last_pos - COUNT_W'(1) || byte_count_q == last_pos)
					&& evt_byte != TAIL_BYTE) begin
				tail_good_d = 1'b0;
			end
			if (byte_count_q >= COUNT_W'(LEN_POS) && byte_count_q == last_pos + COUNT_W'(1)) begin
				crc_good_d = (evt_byte == running_crc_q);
			end
			if (byte_count_q != COUNT_MAX) begin
				byte_count_d = byte_count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			running_crc_q <= '0;
			payload_length_q <= '0;
			captured_id_q <= '0;
			header_good_q <= 1'b1;
			tail_good_q <= 1'b1;
			crc_good_q <= 1'b0;
		end else begin
			byte_count_q <= byte_count_d;
			running_crc_q <= running_crc_d;
			payload_length_q <= payload_length_d;
			captured_id_q <= captured_id_d;
			header_good_q <= header_good_d;
			tail_good_q <= tail_good_d;
			crc_good_q <= crc_good_d;
		end
	end

	always_comb begin
		if (byte_count_q >= COUNT_W'(MAX_BURST)) begin
			result.status = STAT_OVERLONG;
		end else if (byte_count_q < COUNT_W'(2) || !header_good_q) begin
			result.status = STAT_BAD_HEADER;
		end else if (byte_count_q < COUNT_W'(LEN_POS) || byte_count_q < need_count) begin
			result.status = STAT_SHORT;
		end else if (!tail_good_q) begin
			result.status = STAT_BAD_TAIL;
		end else if (!crc_good_q) begin
			result.status = STAT_CRC_MISMATCH;
		end else begin
			result.status = STAT_OK;
		end
		result.id = captured_id_q;
		result.length = 9'(LEN_POS + 3) + {1'b0, payload_length_q};
	end

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_command == CMD_IDLE |=> byte_count_q == '0 && header_good_q)
		else $error("burst state not cleared after idle");
	a_header_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!header_good_q |-> byte_count_q != '0)
		else $error("header flagged bad with no byte counted");
	a_tail_position: assert property (@(posedge clk) disable iff (!arst_n)
		!tail_good_q |-> byte_count_q > COUNT_W'(LEN_POS))
		else $error("tail flagged bad before the tail could arrive");

endmodule

>>> sv/fcc_out_reg.sv
// Result register with valid and stall toward the receiving side.
module fcc_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input fcc_pkg::result_t result,
	input logic result_stall,
	output logic free,
	output logic result_valid,
	output fcc_pkg::result_t result_q
);
	import fcc_pkg::*;

	logic valid_q;

	// The register may take a new result when empty or when its content leaves this cycle.
	assign free = !valid_q || !result_stall;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_q || !result_stall)
		else $error("result overwritten while stalled");

endmodule

>>> sv/frame_check_crc8_receiver.sv
// Framed packet checker with CRC-8 over received UART bytes: top level.
// The block takes one transfer per clock unless item_stall holds it: a received byte or an idle
// event that ends the burst. Each transfer is registered in the input register, then logic
// updates the byte count, the reflected CRC-8 and the header, length, tail and CRC checks. An idle
// event produces one result (status, transaction id, frame length), which is loaded into the result
// register as the event leaves the input register, and the burst state returns to reset. Bytes
// never produce a result and never wait in the input register; only an idle event can wait there,
// and only while a previous result is still stalled, which holds up the transfers behind it.
module frame_check_crc8_receiver (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input logic command,
	input logic [7:0] rx_byte,
	output logic result_valid,
	input logic result_stall,
	output logic [2:0] frame_status,
	output logic [7:0] transaction_id,
	output logic [8:0] frame_length
);
	import fcc_pkg::*;

	logic valid_s1;
	logic command_s1;
	logic [7:0] rx_byte_s1;
	logic out_free;
	logic advance;
	logic accept;
	result_t result;
	result_t result_q;

	assign advance = valid_s1 && (command_s1 == CMD_BYTE || out_free);
	assign item_stall = valid_s1 && !advance;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= command;
			rx_byte_s1 <= rx_byte;
		end
	end

	fcc_tracker u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(advance),
		.evt_command(command_s1),
		.evt_byte(rx_byte_s1),
		.result(result)
	);

	fcc_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && command_s1 == CMD_IDLE),
		.result(result),
		.result_stall(result_stall),
		.free(out_free),
		.result_valid(result_valid),
		.result_q(result_q)
	);

	assign frame_status = result_q.status;
	assign transaction_id = result_q.id;
	assign frame_length = result_q.length;

	a_byte_never_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && command_s1 == CMD_BYTE |-> !item_stall)
		else $error("byte transfer held up");
	a_idle_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && command_s1 == CMD_IDLE |=> result_valid)
		else $error("idle event did not produce a result");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the framed packet checker with CRC-8.
module tb;
	import fcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		frame_status_t status;
		logic [7:0] id;
		logic [8:0] length;
	} frame_result_t;

	typedef enum int {
		CORR_NONE = 0,
		CORR_HEADER = 1,
		CORR_TAIL = 2,
		CORR_CRC = 3,
		CORR_TRUNC = 4,
		CORR_TRAIL = 5,
		CORR_FLIP = 6
	} corrupt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic command = CMD_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [2:0] frame_status;
	logic [7:0] transaction_id;
	logic [8:0] frame_length;

	// Burst state of the predictor.
	logic [COUNT_W-1:0] rx_count;
	logic [7:0] rx_crc;
	logic [7:0] rx_len;
	logic [7:0] rx_id;
	logic hdr_ok;
	logic tail_ok;
	logic crc_ok;

	frame_result_t pending_reports[$];
	logic [7:0] frame_buf[$];
	int gap_pct = 0;
	int stall_pct = 0;
	int sent_items = 0;
	int mismatches = 0;
	int idle_cycles;

	frame_check_crc8_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.frame_status(frame_status),
		.transaction_id(transaction_id),
		.frame_length(frame_length)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] r;
		r = acc ^ data;
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic void clear_burst();
		rx_count = '0;
		rx_crc = 8'h00;
		rx_len = 8'h00;
		rx_id = 8'h00;
		hdr_ok = 1'b1;
		tail_ok = 1'b1;
		crc_ok = 1'b0;
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		int pos;
		int last;
		pos = rx_count;
		last = LEN_POS + 1 + rx_len;
		if (pos < 2 && b != HDR_BYTE) hdr_ok = 1'b0;
		if (pos == ID_POS) rx_id = b;
		if (pos < LEN_POS || pos <= last) rx_crc = crc8_step(rx_crc, b);
		if (pos == LEN_POS - 1) rx_len = b;
		if (pos >= LEN_POS && (pos == last - 1 || pos == last) && b != TAIL_BYTE)
			tail_ok = 1'b0;
		// The CRC byte is compared with the CRC over everything before it.
		if (pos >= LEN_POS && pos == last + 1) crc_ok = (b == rx_crc);
		if (rx_count != COUNT_MAX) rx_count++;
	endfunction

	function automatic void predict_idle();
		frame_result_t r;
		int need;
		need = LEN_POS + 3 + rx_len;
		if (rx_count >= MAX_BURST) r.status = STAT_OVERLONG;
		else if (rx_count < 2 || !hdr_ok) r.status = STAT_BAD_HEADER;
		else if (rx_count < LEN_POS || rx_count < need) r.status = STAT_SHORT;
		else if (!tail_ok) r.status = STAT_BAD_TAIL;
		else if (!crc_ok) r.status = STAT_CRC_MISMATCH;
		else r.status = STAT_OK;
		r.id = rx_id;
		r.length = 9'(need);
		pending_reports.push_back(r);
		clear_burst();
	endfunction

	// One transfer on the item channel, with a random gap in front of it.
	task automatic send_transfer(input logic cmd, input logic [7:0] data);
		int gap;
		gap = 0;
		while ($urandom_range(99) < gap_pct) gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		rx_byte <= data;
		do @(posedge clk); while (item_stall);
		if (cmd == CMD_IDLE) predict_idle();
		else predict_byte(data);
		sent_items++;
	endtask

	task automatic send_burst();
		foreach (frame_buf[i]) send_transfer(CMD_BYTE, frame_buf[i]);
		send_transfer(CMD_IDLE, 8'($urandom));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	function automatic void build_frame(input int plen, input logic [7:0] id, input corrupt_t kind);
		logic [7:0] crc;
		logic [7:0] nz;
		frame_buf.delete();
		frame_buf.push_back(HDR_BYTE);
		frame_buf.push_back(HDR_BYTE);
		frame_buf.push_back(id);
		repeat (LEN_POS - 4) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(plen[7:0]);
		repeat (plen) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(TAIL_BYTE);
		frame_buf.push_back(TAIL_BYTE);
		crc = 8'h00;
		foreach (frame_buf[i]) crc = crc8_step(crc, frame_buf[i]);
		frame_buf.push_back(crc);
		nz = 8'($urandom_range(255, 1));
		case (kind)
			CORR_HEADER: frame_buf[$urandom_range(1)] ^= nz;
			CORR_TAIL: frame_buf[LEN_POS + plen + $urandom_range(1)] ^= nz;
			CORR_CRC: frame_buf[LEN_POS + 2 + plen] ^= nz;
			CORR_TRUNC: repeat ($urandom_range(frame_buf.size(), 1)) void'(frame_buf.pop_back());
			CORR_TRAIL: repeat ($urandom_range(5, 1)) frame_buf.push_back(8'($urandom));
			CORR_FLIP: frame_buf[$urandom_range(frame_buf.size() - 1)] ^= nz;
			default: ;
		endcase
	endfunction

	// Empty burst, a bad header byte, too few bytes for the length, one clean frame.
	task automatic test_basic_bursts();
		frame_buf.delete();
		send_burst();
		frame_buf = '{8'hFF, HDR_BYTE};
		send_burst();
		frame_buf = '{HDR_BYTE, HDR_BYTE, 8'h7E};
		send_burst();
		build_frame(0, 8'hFF, CORR_NONE);
		send_burst();
	endtask

	task automatic test_frame_errors();
		for (int k = CORR_NONE; k <= CORR_FLIP; k++) begin
			build_frame($urandom_range(3), (k == CORR_NONE) ? 8'h00 : 8'($urandom), corrupt_t'(k));
			send_burst();
		end
	endtask

	// Largest payload, the overlong boundary and a count that saturates.
	task automatic test_long_bursts();
		build_frame(255, 8'($urandom), CORR_NONE);
		send_burst();
		build_frame(255, 8'($urandom), CORR_NONE);
		while (frame_buf.size() < MAX_BURST - 1) frame_buf.push_back(8'($urandom));
		send_burst();
		build_frame(255, 8'($urandom), CORR_NONE);
		while (frame_buf.size() < MAX_BURST) frame_buf.push_back(8'($urandom));
		send_burst();
		build_frame(2, 8'($urandom), CORR_NONE);
		while (frame_buf.size() < 1030) frame_buf.push_back(8'($urandom));
		send_burst();
	endtask

	task automatic test_random_traffic(input int gap_p, input int stall_p, input int quota);
		int start;
		int plen;
		corrupt_t kind;
		gap_pct = gap_p;
		stall_pct = stall_p;
		start = sent_items;
		while (sent_items - start < quota) begin
			if ($urandom_range(99) < 70) begin
				plen = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(6);
				kind = ($urandom_range(1) == 0) ? CORR_NONE : corrupt_t'($urandom_range(CORR_FLIP));
				build_frame(plen, 8'($urandom), kind);
			end else begin
				frame_buf.delete();
				repeat ($urandom_range(20)) frame_buf.push_back(8'($urandom));
			end
			send_burst();
		end
	endtask

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d id %0d length %0d",
						frame_status, transaction_id, frame_length);
			end else begin
				want = pending_reports.pop_front();
				if (frame_status !== want.status || transaction_id !== want.id ||
						frame_length !== want.length) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							want.status, want.id, want.length,
							frame_status, transaction_id, frame_length);
				end
			end
		end
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Ends the run when no transfer happens on either channel for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		clear_burst();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_bursts();
		test_frame_errors();
		wait_drained();
		gap_pct = 20;
		stall_pct = 20;
		test_long_bursts();
		wait_drained();
		test_random_traffic(0, 0, 100);
		test_random_traffic(78, 0, 100);
		wait_drained();
		test_random_traffic(0, 78, 100);
		test_random_traffic(20, 20, 100);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
